### hdl/battery_voltage_to_percent_gauge_assert.svh
// Assertion macros shared by the battery gauge checker.
`ifndef BATTERY_VOLTAGE_TO_PERCENT_GAUGE_ASSERT_SVH
`define BATTERY_VOLTAGE_TO_PERCENT_GAUGE_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define BVG_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("battery gauge assertion failed");

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define BVG_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("battery gauge assertion failed");

`endif

### hdl/bvg_pkg.sv
// Shared types, constants and the discharge curve table of the battery gauge.
`default_nettype none

package bvg_pkg;

  // Defaults of the top-level parameters.
  localparam int ADC_BITS_DEF   = 10;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field and datapath widths.
  localparam int TIME_W     = 32;
  localparam int SUM_W      = 32;
  localparam int PCT_W      = 7;
  localparam int AVG_OUT_W  = 13;
  localparam int OUT_DATA_W = ((PCT_W + AVG_OUT_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = '0;

  // Reset values.
  localparam logic [TIME_W-1:0] WINDOW_LENGTH_RST = 32'd10000;
  localparam logic [TIME_W-1:0] WINDOW_START_RST  = 32'd10000;

  // Millivolts = 3000 + (sample - 496) * 6, which folds to 24 + 6 * sample.
  localparam int MV_OFFSET = 24;
  localparam int MV_SCALE  = 6;

  // Discharge curve.
  localparam int CURVE_W    = 13;
  localparam int SEG_DIV_W  = 5;
  localparam int CURVE_SEGS = 11;
  localparam int FULL_MV    = 4145;
  localparam int PCT_FULL   = 100;
  localparam int DIFF_W     = 8;

  typedef struct packed {
    logic [CURVE_W-1:0]   above;
    logic [PCT_W-1:0]     base;
    logic [CURVE_W-1:0]   top;
    logic [SEG_DIV_W-1:0] dvs;
  } seg_t;

  localparam seg_t CURVE [CURVE_SEGS] = '{
    '{13'd4010, 7'd99, 13'd4145, 5'd13},
    '{13'd3920, 7'd90, 13'd4010, 5'd9},
    '{13'd3850, 7'd80, 13'd3920, 5'd7},
    '{13'd3789, 7'd70, 13'd3850, 5'd6},
    '{13'd3740, 7'd60, 13'd3789, 5'd4},
    '{13'd3703, 7'd50, 13'd3740, 5'd3},
    '{13'd3676, 7'd40, 13'd3703, 5'd2},
    '{13'd3648, 7'd30, 13'd3676, 5'd2},
    '{13'd3609, 7'd20, 13'd3648, 5'd3},
    '{13'd3575, 7'd10, 13'd3609, 5'd6},
    '{13'd3482, 7'd5,  13'd3575, 5'd18}
  };

  // Shared divider.
  localparam int DIV_STEPS_W = 6;
  localparam logic [DIV_STEPS_W-1:0] AVG_STEPS  = DIV_STEPS_W'(SUM_W);
  localparam logic [DIV_STEPS_W-1:0] DROP_STEPS = DIV_STEPS_W'(DIFF_W);

  typedef struct packed {
    logic                   start;
    logic [DIV_STEPS_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic [PCT_W-1:0]     percent;
    logic                 refreshed;
    logic [AVG_OUT_W-1:0] average_mv;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_AVG,
    ST_MAP,
    ST_DROP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### hdl/battery_voltage_to_percent_gauge.sv
// Top level of the battery gauge: stream ports, configuration register and result register.
// Path: one beat at a time. A beat that closes no window passes ACCUM and DONE to reach the
// output register; the first beat also maps the curve (MAP, then DROP unless full or empty),
// and a closing beat averages (AVG) first. DONE waits for a free output slot, and a new beat
// is taken once the result lands (32-step average and 8-step drop divides).
// Reset: synchronous, active low; all control and window state return to their defaults.
`default_nettype none

module battery_voltage_to_percent_gauge #(
  parameter int ADC_BITS   = bvg_pkg::ADC_BITS_DEF,
  parameter int COUNT_BITS = bvg_pkg::COUNT_BITS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  // Input beats: tdata holds adc_sample from bit 0, then now_ms, zero filled.
  input  logic                                                in_tvalid,
  output logic                                                in_tready,
  input  logic [((ADC_BITS + bvg_pkg::TIME_W + 7) / 8) * 8 - 1:0] in_tdata,
  // Result beats: tdata holds percent from bit 0, then average_mv, zero filled.
  output logic                                                out_tvalid,
  input  logic                                                out_tready,
  output logic [bvg_pkg::OUT_DATA_W-1:0]                      out_tdata,
  // tuser holds refreshed.
  output logic                                                out_tuser,
  // Configuration port.
  input  logic                                                cfg_psel,
  input  logic                                                cfg_penable,
  input  logic                                                cfg_pwrite,
  input  logic [bvg_pkg::CFG_ADDR_W-1:0]                      cfg_paddr,
  input  logic [bvg_pkg::CFG_DATA_W-1:0]                      cfg_pwdata,
  output logic [bvg_pkg::CFG_DATA_W-1:0]                      cfg_prdata,
  output logic                                                cfg_pready
);

  import bvg_pkg::*;

  // Configuration: the single register is the window length in milliseconds.
  logic [TIME_W-1:0]    win_len_r, win_len_nxt;
  logic                 cfg_hit;
  logic                 cfg_wr;

  // Result register, which lets the sequencer finish the next beat while this one waits.
  logic                 out_valid_r, out_valid_nxt;
  result_t              out_res_r, out_res_nxt;
  logic                 slot_free;

  // Links between the sequencer and the shared divider.
  div_req_t             div_req;
  logic [SUM_W-1:0]     div_dividend;
  logic [COUNT_BITS-1:0] div_divisor;
  logic                 div_done;
  logic [SUM_W-1:0]     div_quotient;
  logic                 res_push;
  result_t              res;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_ADDR_W-1:2] == REG_WINDOW_LENGTH);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_hit ? win_len_r : '0;

  always_comb begin
    win_len_nxt = win_len_r;
    if (cfg_wr && cfg_hit) begin
      win_len_nxt = cfg_pwdata[TIME_W-1:0];
    end
  end

  // A slot is free when the register is empty or is being emptied in this cycle.
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_push) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= WINDOW_LENGTH_RST;
      out_valid_r <= 1'b0;
    end else begin
      win_len_r   <= win_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.refreshed;
  assign out_tdata  = {{(OUT_DATA_W - PCT_W - AVG_OUT_W){1'b0}},
                       out_res_r.average_mv, out_res_r.percent};

  // The sequencer owns the window state and drives the divider for both the average and
  // the per-segment drop, one after the other.
  bvg_ctrl #(
    .ADC_BITS   (ADC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_sample     (in_tdata[ADC_BITS-1:0]),
    .in_now        (in_tdata[ADC_BITS +: TIME_W]),
    .window_length (win_len_r),
    .div_req       (div_req),
    .div_dividend  (div_dividend),
    .div_divisor   (div_divisor),
    .div_done      (div_done),
    .div_quotient  (div_quotient),
    .slot_free     (slot_free),
    .res_push      (res_push),
    .res           (res)
  );

  bvg_div #(
    .DVS_W (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

`default_nettype wire

### hdl/bvg_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module bvg_div #(
  parameter int DVS_W = bvg_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bvg_pkg::div_req_t          req,
  input  logic [bvg_pkg::SUM_W-1:0]  dividend,
  input  logic [DVS_W-1:0]           divisor,
  output logic                       done,
  output logic [bvg_pkg::SUM_W-1:0]  quotient
);

  import bvg_pkg::*;

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [DIV_STEPS_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0]       dvd_r, dvd_nxt;
  logic [SUM_W-1:0]       quo_r, quo_nxt;
  logic [DVS_W-1:0]       rem_r, rem_nxt;
  logic [DVS_W-1:0]       dvs_r, dvs_nxt;
  logic [DVS_W:0]         trial;
  logic [DVS_W:0]         trial_sub;

  // The dividend is shifted out from the top; a short divide loads it left aligned
  // and runs only as many steps as it has bits.
  always_comb begin
    trial     = {rem_r, dvd_r[SUM_W-1]};
    trial_sub = trial - {1'b0, dvs_r};
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    dvd_nxt   = dvd_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      dvd_nxt  = dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial_sub[DVS_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      dvd_nxt = {dvd_r[SUM_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_STEPS_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

### hdl/bvg_ctrl.sv
// Sequencer of the battery gauge: window accumulation, averaging and curve mapping.
`default_nettype none

module bvg_ctrl #(
  parameter int ADC_BITS   = bvg_pkg::ADC_BITS_DEF,
  parameter int COUNT_BITS = bvg_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ADC_BITS-1:0]         in_sample,
  input  logic [bvg_pkg::TIME_W-1:0]  in_now,
  input  logic [bvg_pkg::TIME_W-1:0]  window_length,
  output bvg_pkg::div_req_t           div_req,
  output logic [bvg_pkg::SUM_W-1:0]   div_dividend,
  output logic [COUNT_BITS-1:0]       div_divisor,
  input  logic                        div_done,
  input  logic [bvg_pkg::SUM_W-1:0]   div_quotient,
  input  logic                        slot_free,
  output logic                        res_push,
  output bvg_pkg::result_t            res
);

  import bvg_pkg::*;

  localparam int MV_W = ADC_BITS + 3;

  state_t                state_r, state_nxt;
  logic [ADC_BITS-1:0]   sample_r, sample_nxt;
  logic [TIME_W-1:0]     now_r, now_nxt;
  logic [TIME_W-1:0]     start_r, start_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [PCT_W-1:0]      held_r, held_nxt;
  logic                  seeded_r, seeded_nxt;
  logic                  refreshed_r, refreshed_nxt;
  logic [MV_W-1:0]       val_r, val_nxt;
  logic [MV_W-1:0]       avg_r, avg_nxt;
  logic [PCT_W-1:0]      base_r, base_nxt;

  logic [MV_W-1:0]       mv;
  logic                  win_close;
  logic                  count_full;
  logic [SUM_W:0]        sum_add;
  logic [SUM_W-1:0]      sum_acc;
  logic [COUNT_BITS-1:0] count_acc;
  logic                  seg_hit;
  logic [CURVE_W-1:0]    sel_top;
  logic [PCT_W-1:0]      sel_base;
  logic [SEG_DIV_W-1:0]  sel_dvs;
  logic [CURVE_W-1:0]    gap;
  logic [DIFF_W-1:0]     drop;

  assign mv         = MV_W'(MV_OFFSET) + MV_W'(sample_r) * MV_W'(MV_SCALE);
  assign win_close  = (now_r - start_r) > window_length;
  assign count_full = (count_r == {COUNT_BITS{1'b1}});
  assign sum_add    = {1'b0, sum_r} + (SUM_W + 1)'(mv);
  assign sum_acc    = count_full ? sum_r : (sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0]);
  assign count_acc  = count_full ? count_r : count_r + 1'b1;

  // Lowest-numbered segment whose lower bound lies below the value wins.
  always_comb begin
    seg_hit  = 1'b0;
    sel_top  = '0;
    sel_base = '0;
    sel_dvs  = '0;
    for (int i = CURVE_SEGS - 1; i >= 0; i--) begin
      if (val_r > MV_W'(CURVE[i].above)) begin
        seg_hit  = 1'b1;
        sel_top  = CURVE[i].top;
        sel_base = CURVE[i].base;
        sel_dvs  = CURVE[i].dvs;
      end
    end
  end

  // Within a segment the value does not exceed its top, so the gap fits in DIFF_W bits.
  assign gap  = sel_top - val_r[CURVE_W-1:0];
  assign drop = div_quotient[DIFF_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    sample_nxt    = sample_r;
    now_nxt       = now_r;
    start_nxt     = start_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    held_nxt      = held_r;
    seeded_nxt    = seeded_r;
    refreshed_nxt = refreshed_r;
    val_nxt       = val_r;
    avg_nxt       = avg_r;
    base_nxt      = base_r;
    div_req       = '0;
    div_dividend  = {gap[DIFF_W-1:0], {(SUM_W - DIFF_W){1'b0}}};
    div_divisor   = COUNT_BITS'(sel_dvs);
    res_push      = 1'b0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          sample_nxt = in_sample;
          now_nxt    = in_now;
          state_nxt  = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        seeded_nxt = 1'b1;
        if (win_close) begin
          start_nxt     = now_r;
          sum_nxt       = '0;
          count_nxt     = '0;
          refreshed_nxt = 1'b1;
          div_req.start = 1'b1;
          div_req.steps = AVG_STEPS;
          div_dividend  = sum_acc;
          div_divisor   = count_acc;
          state_nxt     = ST_AVG;
        end else begin
          sum_nxt       = sum_acc;
          count_nxt     = count_acc;
          refreshed_nxt = 1'b0;
          avg_nxt       = '0;
          if (!seeded_r) begin
            val_nxt   = mv;
            state_nxt = ST_MAP;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_AVG: begin
        // The count is never zero here, and the average never exceeds the largest sample.
        if (div_done) begin
          val_nxt   = div_quotient[MV_W-1:0];
          avg_nxt   = div_quotient[MV_W-1:0];
          state_nxt = ST_MAP;
        end
      end
      ST_MAP: begin
        if (val_r >= MV_W'(FULL_MV)) begin
          held_nxt  = PCT_W'(PCT_FULL);
          state_nxt = ST_DONE;
        end else if (!seg_hit) begin
          held_nxt  = '0;
          state_nxt = ST_DONE;
        end else begin
          base_nxt      = sel_base;
          div_req.start = 1'b1;
          div_req.steps = DROP_STEPS;
          state_nxt     = ST_DROP;
        end
      end
      ST_DROP: begin
        if (div_done) begin
          held_nxt  = (drop > DIFF_W'(base_r)) ? '0 : base_r - drop[PCT_W-1:0];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res.percent    = held_r;
  assign res.refreshed  = refreshed_r;
  assign res.average_mv = avg_r[AVG_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      start_r  <= WINDOW_START_RST;
      sum_r    <= '0;
      count_r  <= '0;
      held_r   <= '0;
      seeded_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      start_r  <= start_nxt;
      sum_r    <= sum_nxt;
      count_r  <= count_nxt;
      held_r   <= held_nxt;
      seeded_r <= seeded_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r    <= sample_nxt;
    now_r       <= now_nxt;
    refreshed_r <= refreshed_nxt;
    val_r       <= val_nxt;
    avg_r       <= avg_nxt;
    base_r      <= base_nxt;
  end

endmodule

`default_nettype wire

### hdl/bvg_checker.sv
// Port-level checks of the battery gauge and their binding to the top level.
`default_nettype none
`include "battery_voltage_to_percent_gauge_assert.svh"

module bvg_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [bvg_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           out_tuser
);

  import bvg_pkg::*;

  // One beat at a time: the block is busy straight after taking a beat.
  `BVG_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  // A result that did not refresh carries no average.
  `BVG_ASSERT_IMP(a_avg_zero_when_held, out_tvalid && !out_tuser, out_tdata[PCT_W +: AVG_OUT_W] == '0)
  // The percent never leaves its range.
  `BVG_ASSERT_IMP(a_percent_range, out_tvalid, out_tdata[PCT_W-1:0] <= PCT_W'(PCT_FULL))
  // A stalled result beat holds still.
  `BVG_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind battery_voltage_to_percent_gauge bvg_checker u_bvg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

### tb/charge_checker.sv
// Checker for the battery gauge: predicts each reading from accepted beats and compares.
module charge_checker #(
  parameter int IN_W       = 48,
  parameter int COUNT_BITS = bvg_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [IN_W-1:0]                   in_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [bvg_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              out_tuser,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bvg_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [bvg_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  input  logic                              cfg_pready,
  output int                                fault_count,
  output int                                readings_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import bvg_pkg::*;

  localparam logic [31:0] COUNT_CEILING = (32'd1 << COUNT_BITS) - 32'd1;

  logic [31:0]      window_len;
  logic [31:0]      window_start;
  logic [31:0]      mv_sum;
  logic [31:0]      sample_cnt;
  logic [PCT_W-1:0] held_pct;
  logic             seeded;
  result_t          due_readings[$];
  int               faults = 0;
  int               readings_seen;

  // One straight segment of the discharge curve, clamped at zero.
  function automatic logic [PCT_W-1:0] segment_pct(input int unsigned base,
                                                   input int unsigned top,
                                                   input int unsigned dv,
                                                   input logic [31:0] mv);
    int unsigned drop;
    drop = (top - mv) / dv;
    return (drop > base) ? '0 : PCT_W'(base - drop);
  endfunction

  function automatic logic [PCT_W-1:0] charge_percent(input logic [31:0] mv);
    if (mv >= 32'd4145) return 7'd100;
    if (mv > 32'd4010)  return segment_pct(99, 4145, 13, mv);
    if (mv > 32'd3920)  return segment_pct(90, 4010, 9, mv);
    if (mv > 32'd3850)  return segment_pct(80, 3920, 7, mv);
    if (mv > 32'd3789)  return segment_pct(70, 3850, 6, mv);
    if (mv > 32'd3740)  return segment_pct(60, 3789, 4, mv);
    if (mv > 32'd3703)  return segment_pct(50, 3740, 3, mv);
    if (mv > 32'd3676)  return segment_pct(40, 3703, 2, mv);
    if (mv > 32'd3648)  return segment_pct(30, 3676, 2, mv);
    if (mv > 32'd3609)  return segment_pct(20, 3648, 3, mv);
    if (mv > 32'd3575)  return segment_pct(10, 3609, 6, mv);
    if (mv > 32'd3482)  return segment_pct(5, 3575, 18, mv);
    return '0;
  endfunction

  // Folds one sample into the window and queues the reading it produces.
  task automatic advance_gauge(input logic [9:0] sample, input logic [31:0] now);
    logic [31:0] mv;
    logic [32:0] total;
    logic [31:0] elapsed;
    logic [31:0] avg;
    result_t     r;
    mv  = 32'd24 + 32'd6 * {22'd0, sample};
    avg = '0;
    r.refreshed = 1'b0;
    if (!seeded) begin
      held_pct = charge_percent(mv);
      seeded   = 1'b1;
    end
    if (sample_cnt < COUNT_CEILING) begin
      total      = {1'b0, mv_sum} + {1'b0, mv};
      mv_sum     = total[32] ? '1 : total[31:0];
      sample_cnt = sample_cnt + 32'd1;
    end
    elapsed = now - window_start;
    if (elapsed > window_len) begin
      window_start = now;
      avg          = (sample_cnt != 0) ? mv_sum / sample_cnt : '0;
      held_pct     = charge_percent(avg);
      sample_cnt   = '0;
      mv_sum       = '0;
      r.refreshed  = 1'b1;
    end
    r.percent    = held_pct;
    r.average_mv = avg[AVG_OUT_W-1:0];
    due_readings.push_back(r);
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      window_len    = WINDOW_LENGTH_RST;
      window_start  = WINDOW_START_RST;
      mv_sum        = '0;
      sample_cnt    = '0;
      held_pct      = '0;
      seeded        = 1'b0;
      readings_seen = 0;
      due_readings.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_ADDR_W-1:2] == REG_WINDOW_LENGTH)
        window_len = cfg_pwdata;
      if (in_tvalid && in_tready)
        advance_gauge(in_tdata[9:0], in_tdata[41:10]);
      if (out_tvalid && out_tready) begin
        got.percent    = out_tdata[PCT_W-1:0];
        got.average_mv = out_tdata[PCT_W+AVG_OUT_W-1:PCT_W];
        got.refreshed  = out_tuser;
        if (due_readings.size() == 0) begin
          faults = faults + 1;
          if (faults <= 10)
            $display("reading %0d arrived unasked: percent %0d refreshed %0b average %0d",
                     readings_seen, got.percent, got.refreshed, got.average_mv);
        end else begin
          want = due_readings.pop_front();
          if (got !== want) begin
            faults = faults + 1;
            if (faults <= 10)
              $display("reading %0d: expected pct %0d ref %0b avg %0d, got pct %0d ref %0b avg %0d",
                       readings_seen, want.percent, want.refreshed, want.average_mv,
                       got.percent, got.refreshed, got.average_mv);
          end
        end
        readings_seen = readings_seen + 1;
      end
    end
    fault_count  <= faults;
    readings_due <= due_readings.size();
  end

endmodule

### tb/tb_top.sv
// Top of the battery gauge testbench: clock, reset, stimulus, configuration and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W        = ((bvg_pkg::ADC_BITS_DEF + bvg_pkg::TIME_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 4_000_000;
  // Back-to-back beats sent at the longest window with no idling.
  localparam int FLOOD_BEATS = 30;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  // in_tdata: adc_sample [9:0], now_ms [41:10], zeros above.
  logic [IN_W-1:0]                 in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // out_tdata: percent [6:0], average_mv [19:7], zeros above.
  logic [bvg_pkg::OUT_DATA_W-1:0]  out_tdata;
  // out_tuser: refreshed [0].
  logic                            out_tuser;
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [bvg_pkg::CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [bvg_pkg::CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [bvg_pkg::CFG_DATA_W-1:0]  cfg_prdata;
  logic                            cfg_pready;

  int fault_count;
  int readings_due;
  int cycle_cnt = 0;

  // The stimulus keeps its own view of the window length and window start so that it can
  // aim beats exactly at the closing boundary; the checker does the real prediction.
  logic [31:0] window_len = bvg_pkg::WINDOW_LENGTH_RST;
  logic [31:0] win_start  = bvg_pkg::WINDOW_START_RST;
  logic [31:0] cur_now    = '0;
  // While set, both the sender and the receiver pause in random bursts.
  logic        idling     = 1'b1;

  // Samples whose single-sample windows land in each segment of the discharge curve,
  // including both sides of the full-charge threshold and of the empty threshold.
  localparam logic [19:0][9:0] CURVE_PROBES = {
    10'd0,   10'd576, 10'd577, 10'd590, 10'd596, 10'd598, 10'd604, 10'd608, 10'd612, 10'd615,
    10'd620, 10'd627, 10'd632, 10'd638, 10'd645, 10'd650, 10'd664, 10'd665, 10'd686, 10'd687
  };

  always #5 clk = ~clk;

  battery_voltage_to_percent_gauge i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  charge_checker #(.IN_W(IN_W)) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fault_count (fault_count),
    .readings_due(readings_due)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: ready for a random stretch, occasionally a long one, then a stall burst
  // whilst idling is enabled.
  initial begin
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 40)) @(posedge clk);
      if (idling) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Presents one beat and holds it until it is taken. tvalid stays high on return, so a
  // following beat continues without a bubble unless a gap is drawn.
  task automatic send_sample(input logic [9:0] sample, input logic [31:0] now);
    in_tdata  <= IN_W'({now, sample});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    cur_now = now;
    if (now - win_start > window_len)
      win_start = now;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every predicted reading has been received. The first
  // edge lets the checker's count catch up with a beat taken in this very step.
  task automatic drain_readings;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (readings_due != 0) @(posedge clk);
  endtask

  // Setup cycle then access cycle; the register takes the value at the access edge.
  task automatic write_window_length(input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {bvg_pkg::REG_WINDOW_LENGTH, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    window_len = value;
  endtask

  // Most samples sit on the interesting part of the curve; most times creep forward so
  // that several beats share a window. The rest land on or one past the closing boundary, jump
  // to a random time (wrapping included) or repeat the previous time.
  task automatic send_random_sample;
    logic [9:0]  sample;
    logic [31:0] now;
    int          pick;
    sample = ($urandom_range(0, 9) < 6) ? 10'($urandom_range(570, 700))
                                        : 10'($urandom_range(0, 1023));
    pick = $urandom_range(0, 9);
    if (pick == 7)
      now = win_start + window_len + $urandom_range(0, 1);
    else if (pick == 8)
      now = $urandom;
    else if (pick == 9)
      now = cur_now;
    else
      now = cur_now + $urandom_range(0, window_len / 6 + 1);
    send_sample(sample, now);
  endtask

  initial begin
    int i;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset window length of 10000 ms. The first beat seeds the
    // percent from a full-scale sample; the second lands exactly on the window length and
    // must not close it; the third is one past and closes a three-sample window.
    send_sample(10'd1023, 32'd10000);
    send_sample(10'd0, 32'd20000);
    send_sample(10'd341, 32'd20001);
    // Each probe closes a window of its own, so its average is its own millivolts.
    for (i = 0; i < 20; i++)
      send_sample(CURVE_PROBES[i], win_start + window_len + 32'd1);
    drain_readings();

    // Moderate window, with one full pause of the sender halfway through.
    write_window_length($urandom_range(50, 500));
    for (i = 0; i < 400; i++) begin
      if (i == 200)
        drain_readings();
      send_random_sample();
    end
    drain_readings();

    // Shortest window: closes as soon as two milliseconds have passed.
    write_window_length(32'd1);
    for (i = 0; i < 300; i++)
      send_random_sample();
    drain_readings();

    write_window_length($urandom);
    for (i = 0; i < 400; i++)
      send_random_sample();
    drain_readings();

    // Longest window: nothing can ever close it, so the sum keeps growing.
    // The closing burst runs without idling.
    write_window_length(32'hFFFF_FFFF);
    for (i = 0; i < 100; i++)
      send_random_sample();
    idling = 1'b0;
    for (i = 0; i < FLOOD_BEATS; i++)
      send_sample(10'($urandom_range(0, 1023)), $urandom);
    drain_readings();
    idling = 1'b1;

    // Short window; the first beat closes the long-running window.
    write_window_length($urandom_range(2, 20));
    send_sample(10'($urandom_range(0, 1023)), win_start + window_len + 32'd1);
    for (i = 0; i < 300; i++)
      send_random_sample();
    drain_readings();

    // Last part: long window and no idling on either side.
    write_window_length($urandom_range(1000, 100000));
    idling = 1'b0;
    for (i = 0; i < 300; i++)
      send_random_sample();
    drain_readings();

    // Allow for the slowest result path before judging.
    repeat (60) @(posedge clk);
    if (fault_count == 0 && readings_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/bvg_pkg.sv
hdl/bvg_div.sv
hdl/bvg_ctrl.sv
hdl/battery_voltage_to_percent_gauge.sv
hdl/bvg_checker.sv
tb/charge_checker.sv
tb/tb_top.sv
